// File: design/wmf_pkg.sv
// Package for the windowed median filter.
// Holds shared types and fixed constants; no dependencies.
package wmf_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_PIXEL_FORMAT  = 2'd1,
    REG_PADDED_WIDTH  = 2'd2,
    REG_PADDED_HEIGHT = 2'd3
  } wmf_reg_t;

  // Pixel formats.
  localparam logic FMT_GRAY = 1'b0;
  localparam logic FMT_ARGB = 1'b1;

  localparam int PIX_W     = 32;
  localparam int KEY_W     = 8;
  localparam int SUM_W     = 18;
  localparam int ROW_W     = 12;
  localparam int HGT_W     = 13;
  localparam int CFG_W     = 13;
  localparam int MAX_HEIGHT = 4096;

  // Luma weights and the reciprocal of 1000 scaled by 2^28 (rounded up).
  localparam logic [9:0]  LUMA_R     = 10'd299;
  localparam logic [9:0]  LUMA_G     = 10'd587;
  localparam logic [9:0]  LUMA_B     = 10'd114;
  localparam logic [18:0] LUMA_RECIP = 19'd268436;
  localparam int          LUMA_SHIFT = 28;

  // Control that travels with a pixel through the pipeline.
  typedef struct packed {
    logic vld;
    logic emit;
    logic last;
  } wmf_ctl_t;

endpackage

// File: design/wmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module wmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; the read sees the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/wmf_column.sv
// Column builder: gathers a new window column from the line memories,
// computes each pixel's key (gray byte or luma) and shifts the window.
// Depends on wmf_pkg.
module wmf_column #(
  parameter int MAX_WINDOW = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        fmt,
  input  wmf_pkg::wmf_ctl_t           ctl_in,
  input  logic [31:0]                 pix_in,
  input  logic [$clog2(MAX_WINDOW-1)-1:0] slot_in,
  input  logic [31:0]                 line_data [MAX_WINDOW-1],
  output logic [31:0]                 win_val [MAX_WINDOW*MAX_WINDOW],
  output logic [7:0]                  win_key [MAX_WINDOW*MAX_WINDOW],
  output logic                        emit_out,
  output logic                        last_out
);
  import wmf_pkg::*;

  localparam int MW = MAX_WINDOW;
  localparam int SL = MAX_WINDOW - 1;
  localparam int SW = $clog2(SL);

  // Column stage.
  logic [PIX_W-1:0] col_val_r [MW];
  logic [SUM_W-1:0] col_sum_r [MW];
  wmf_ctl_t         ctl2_r;

  // Window stage, indexed [line distance][column], newest column last.
  logic [PIX_W-1:0] win_val_r [MW][MW];
  logic [KEY_W-1:0] win_key_r [MW][MW];
  logic             emit3_r;
  logic             last3_r;

  logic [PIX_W-1:0] col_val [MW];
  logic [SUM_W-1:0] col_sum [MW];

  // Pick each lane's source and form the weighted color sum.
  always_comb begin
    for (int d = 0; d < MW; d++) begin
      logic [SW:0] s;
      s = SW'(0) + {1'b0, slot_in} + (SW+1)'(SL) - (SW+1)'(d);
      if (s >= (SW+1)'(SL)) begin
        s = s - (SW+1)'(SL);
      end
      if (d == 0) begin
        col_val[d] = pix_in;
      end else begin
        col_val[d] = line_data[s[SW-1:0]];
      end
      col_sum[d] = SUM_W'(LUMA_R * col_val[d][23:16])
                 + SUM_W'(LUMA_G * col_val[d][15:8])
                 + SUM_W'(LUMA_B * col_val[d][7:0]);
    end
  end

  // Column stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (adv) begin
      ctl2_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_in.vld) begin
      col_val_r <= col_val;
      col_sum_r <= col_sum;
    end
  end

  // Shift the window one column and insert the new column with its keys.
  always_ff @(posedge clk) begin
    if (adv && ctl2_r.vld) begin
      for (int d = 0; d < MW; d++) begin
        logic [SUM_W+18:0] prod;
        prod = (SUM_W+19)'(col_sum_r[d]) * (SUM_W+19)'(LUMA_RECIP);
        for (int j = 0; j + 1 < MW; j++) begin
          win_val_r[d][j] <= win_val_r[d][j+1];
          win_key_r[d][j] <= win_key_r[d][j+1];
        end
        win_val_r[d][MW-1] <= col_val_r[d];
        win_key_r[d][MW-1] <= (fmt == FMT_GRAY) ? col_val_r[d][7:0]
                                                : prod[LUMA_SHIFT +: KEY_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit3_r <= 1'b0;
      last3_r <= 1'b0;
    end else if (adv) begin
      emit3_r <= ctl2_r.vld && ctl2_r.emit;
      last3_r <= ctl2_r.last;
    end
  end

  // Flatten the window for the ranking stages.
  always_comb begin
    for (int d = 0; d < MW; d++) begin
      for (int j = 0; j < MW; j++) begin
        win_val[d*MW + j] = win_val_r[d][j];
        win_key[d*MW + j] = win_key_r[d][j];
      end
    end
  end

  assign emit_out = emit3_r;
  assign last_out = last3_r;

endmodule

// File: design/wmf_rank.sv
// Median selection: pairwise key compares, rank counts, one-hot pick and
// the output register. Depends on wmf_pkg.
module wmf_rank #(
  parameter int MAX_WINDOW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          fmt,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] side,
  input  logic [31:0]                   win_val [MAX_WINDOW*MAX_WINDOW],
  input  logic [7:0]                    win_key [MAX_WINDOW*MAX_WINDOW],
  input  logic                          emit_in,
  input  logic                          last_in,
  output logic                          out_valid,
  output logic [31:0]                   median_pixel,
  output logic                          frame_last
);
  import wmf_pkg::*;

  localparam int MW = MAX_WINDOW;
  localparam int N  = MAX_WINDOW * MAX_WINDOW;
  localparam int KW = $clog2(MAX_WINDOW+1);
  localparam int PW = $clog2(N+1);

  logic [N-1:0]     lt4_r [N];
  logic [N-1:0]     act4_r;
  logic [PIX_W-1:0] val4_r [N];
  logic             emit4_r;
  logic             last4_r;

  logic [N-1:0]     match5_r;
  logic [PIX_W-1:0] val5_r [N];
  logic             emit5_r;
  logic             last5_r;

  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;
  logic             out_valid_r;

  logic [N-1:0]     lt [N];
  logic [N-1:0]     act;
  logic [N-1:0]     match;
  logic [PW-1:0]    target;
  logic [PIX_W-1:0] pick;

  // Active window cells and the middle rank for the current side.
  always_comb begin
    logic [2*KW-1:0] sq;
    sq = (2*KW)'(side) * (2*KW)'(side);
    target = PW'((sq - (2*KW)'(1)) >> 1);
    for (int p = 0; p < N; p++) begin
      act[p] = (KW'(p / MW) < side) && (KW'(p % MW) >= KW'(MW) - side);
    end
  end

  // Element q counts below p when its key is smaller, or equal and it comes
  // first in row-major order (larger line distance, then smaller column).
  always_comb begin
    for (int p = 0; p < N; p++) begin
      for (int q = 0; q < N; q++) begin
        logic first;
        first = (q / MW > p / MW) || ((q / MW == p / MW) && (q % MW < p % MW));
        lt[p][q] = act[q] && ((win_key[q] < win_key[p]) ||
                              ((win_key[q] == win_key[p]) && first));
      end
    end
  end

  // Compare stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      lt4_r  <= lt;
      act4_r <= act;
      val4_r <= win_val;
    end
  end

  always_comb begin
    for (int p = 0; p < N; p++) begin
      match[p] = act4_r[p] && (PW'($countones(lt4_r[p])) == target);
    end
  end

  // Rank stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      match5_r <= match;
      val5_r   <= val4_r;
    end
  end

  always_comb begin
    pick = '0;
    for (int p = 0; p < N; p++) begin
      pick = pick | (match5_r[p] ? val5_r[p] : '0);
    end
    if (fmt == FMT_GRAY) begin
      pick = {24'd0, pick[7:0]};
    end
  end

  // Control along the ranking stages and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit4_r     <= 1'b0;
      last4_r     <= 1'b0;
      emit5_r     <= 1'b0;
      last5_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (adv) begin
      emit4_r     <= emit_in;
      last4_r     <= last_in;
      emit5_r     <= emit4_r;
      last5_r     <= last4_r;
      out_valid_r <= emit5_r;
      out_last_r  <= last5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit5_r) begin
      out_pix_r <= pick;
    end
  end

  assign out_valid    = out_valid_r;
  assign median_pixel = out_pix_r;
  assign frame_last   = out_last_r;

endmodule

// File: design/windowed_median_filter.sv
// Top level of the windowed median filter: configuration, raster counters,
// line memories and the column and ranking pipelines.
// Depends on wmf_pkg, wmf_ram, wmf_column and wmf_rank.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_pixel_in
//   out      output     out_valid / out_stall out_median_pixel, out_frame_last
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// One pixel is taken per cycle while in_stall is low. The throughput is set
// by the line memories, all read once per pixel at the same column, where
// the current slot's memory is also written. Reset is synchronous and needs
// no clearing pass. When a result waits with out_stall high, the whole
// pipeline holds and in_stall rises in the same cycle.
module windowed_median_filter #(
  parameter int MAX_LINE   = 2048,
  parameter int MAX_WINDOW = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_median_pixel,
  output logic        out_frame_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);
  import wmf_pkg::*;

  localparam int SL = MAX_WINDOW - 1;
  localparam int SW = $clog2(SL);
  localparam int CW = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int KW = $clog2(MAX_WINDOW + 1);

  // Configuration registers.
  logic [2:0]  window_size_r;
  logic        pixel_format_r;
  logic [11:0] padded_width_r;
  logic [12:0] padded_height_r;

  // Raster position.
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;

  // First pipeline stage.
  wmf_ctl_t   ctl1_r;
  logic [31:0] pix1_r;
  logic [SW-1:0] slot1_r;

  logic          adv;
  logic          accept;
  logic [KW-1:0] side;
  logic [LW-1:0] wid;
  logic [HGT_W-1:0] hgt;
  wmf_ctl_t      ctl_new;
  logic [31:0]   line_data [SL];
  logic [31:0]   win_val [MAX_WINDOW*MAX_WINDOW];
  logic [7:0]    win_key [MAX_WINDOW*MAX_WINDOW];
  logic          emit3;
  logic          last3;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Effective window side, width and height.
  always_comb begin
    logic [2:0]  k;
    logic [31:0] w;
    logic [31:0] h;
    k = (window_size_r < 3'd3) ? 3'd3 : window_size_r;
    if (32'(k) > 32'(MAX_WINDOW)) begin
      k = 3'(MAX_WINDOW);
    end
    if (!k[0]) begin
      k = k - 3'd1;
    end
    side = KW'(k);
    w = 32'(padded_width_r);
    if (w < 32'd4) w = 32'd4;
    if (w > 32'(MAX_LINE)) w = 32'(MAX_LINE);
    wid = LW'(w);
    h = 32'(padded_height_r);
    if (h < 32'd4) h = 32'd4;
    if (h > 32'(MAX_HEIGHT)) h = 32'(MAX_HEIGHT);
    hgt = HGT_W'(h);
  end

  // Output window test for the current position, and the next position.
  always_comb begin
    logic [LW:0]    c2;
    logic [HGT_W:0] r2;
    c2 = (LW+1)'(col_r) + (LW+1)'(2);
    r2 = (HGT_W+1)'(row_r) + (HGT_W+1)'(2);
    ctl_new.vld  = 1'b1;
    ctl_new.emit = (32'(row_r) >= 32'(side) - 32'd1) &&
                   (32'(col_r) >= 32'(side) - 32'd1) &&
                   (r2 <= (HGT_W+1)'(hgt)) && (c2 <= (LW+1)'(wid));
    ctl_new.last = (r2 == (HGT_W+1)'(hgt)) && (c2 == (LW+1)'(wid));

    col_nxt  = col_r + CW'(1);
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if ((LW+1)'(col_r) + (LW+1)'(1) >= (LW+1)'(wid)) begin
      col_nxt  = '0;
      row_nxt  = row_r + ROW_W'(1);
      slot_nxt = (slot_r == SW'(SL - 1)) ? '0 : slot_r + SW'(1);
      if ((HGT_W+1)'(row_r) + (HGT_W+1)'(1) >= (HGT_W+1)'(hgt)) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end
    end
  end

  // Configuration writes restart the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= 3'd3;
      pixel_format_r  <= FMT_GRAY;
      padded_width_r  <= 12'd2048;
      padded_height_r <= 13'd4096;
      col_r           <= '0;
      row_r           <= '0;
      slot_r          <= '0;
    end else if (cfg_we) begin
      unique case (wmf_reg_t'(cfg_index))
        REG_WINDOW_SIZE:   window_size_r   <= cfg_wdata[2:0];
        REG_PIXEL_FORMAT:  pixel_format_r  <= cfg_wdata[0];
        REG_PADDED_WIDTH:  padded_width_r  <= cfg_wdata[11:0];
        REG_PADDED_HEIGHT: padded_height_r <= cfg_wdata[12:0];
        default: ;
      endcase
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Stage one: the beat waits here for the line memory read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (adv) begin
      ctl1_r <= accept ? ctl_new : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r  <= in_pixel_in;
      slot1_r <= slot_r;
    end
  end

  // One line memory per stored line, all read at the current column.
  for (genvar i = 0; i < SL; i++) begin : g_line
    wmf_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_LINE)
    ) u_line (
      .clk  (clk),
      .we   (accept && (slot_r == SW'(i))),
      .waddr(col_r),
      .wdata(in_pixel_in),
      .re   (accept),
      .raddr(col_r),
      .rdata(line_data[i])
    );
  end

  wmf_column #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_column (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .fmt      (pixel_format_r),
    .ctl_in   (ctl1_r),
    .pix_in   (pix1_r),
    .slot_in  (slot1_r),
    .line_data(line_data),
    .win_val  (win_val),
    .win_key  (win_key),
    .emit_out (emit3),
    .last_out (last3)
  );

  wmf_rank #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_rank (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .fmt         (pixel_format_r),
    .side        (side),
    .win_val     (win_val),
    .win_key     (win_key),
    .emit_in     (emit3),
    .last_in     (last3),
    .out_valid   (out_valid),
    .median_pixel(out_median_pixel),
    .frame_last  (out_frame_last)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for windowed_median_filter.
// Depends on wmf_pkg and the RTL; predicts each median beat and compares in order.
module tb_top;
  import wmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pixel_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_median_pixel;
  logic        out_frame_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  windowed_median_filter dut (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic [31:0] median;
    logic        last;
  } median_beat_t;

  // Shadow copy of the filter state.
  logic [31:0] line_mem[6][2048];
  logic [31:0] win[7][7];
  int unsigned col_pos, row_pos;
  logic [2:0]  cfg_side;
  logic        cfg_fmt;
  logic [11:0] cfg_width;
  logic [12:0] cfg_height;

  median_beat_t pending_medians[$];
  int errors = 0, beats_sent = 0, beats_checked = 0, cfg_writes = 0, frames_done = 0;
  int burst_left = 0;

  function automatic int unsigned eff_side();
    int unsigned v = cfg_side;
    if (v < 3) v = 3;
    if (v > 7) v = 7;
    if (v % 2 == 0) v = v - 1;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    int unsigned v = cfg_width;
    if (v < 4) v = 4;
    if (v > 2048) v = 2048;
    return v;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned v = cfg_height;
    if (v < 4) v = 4;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return v;
  endfunction

  function automatic int unsigned luma_key(logic [31:0] p);
    if (cfg_fmt == FMT_GRAY) return p[7:0];
    return (299 * p[23:16] + 587 * p[15:8] + 114 * p[7:0]) / 1000;
  endfunction

  // Register write as the filter sees it: takes effect now and restarts the frame.
  function automatic void shadow_cfg(wmf_reg_t idx, logic [12:0] v);
    case (idx)
      REG_WINDOW_SIZE:   cfg_side = v[2:0];
      REG_PIXEL_FORMAT:  cfg_fmt = v[0];
      REG_PADDED_WIDTH:  cfg_width = v[11:0];
      REG_PADDED_HEIGHT: cfg_height = v;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advance the shadow by one pixel and queue the median it completes, if any.
  function automatic void predict_median(logic [31:0] pix);
    int unsigned k, w, h, c, r, n, rank, d;
    logic [31:0] vals[49];
    int unsigned keys[49];
    median_beat_t m;
    k = eff_side();
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    for (int i = 0; i < 7; i++)
      for (int j = 0; j < 6; j++) win[i][j] = win[i][j+1];
    for (int i = 0; i < k; i++) begin
      d = k - 1 - i;
      win[i][6] = (d == 0) ? pix : line_mem[(r % 6 + 6 - d) % 6][c];
    end
    line_mem[r % 6][c] = pix;
    if (r >= k - 1 && c >= k - 1 && r + 2 <= h && c + 2 <= w) begin
      n = k * k;
      for (int i = 0; i < k; i++)
        for (int j = 0; j < k; j++) begin
          vals[i*k+j] = win[i][7-k+j];
          keys[i*k+j] = luma_key(vals[i*k+j]);
        end
      m.median = '0;
      for (int p = 0; p < n; p++) begin
        rank = 0;
        for (int q = 0; q < n; q++)
          if (keys[q] < keys[p] || (keys[q] == keys[p] && q < p)) rank++;
        if (rank == (n - 1) / 2) begin
          m.median = vals[p];
          break;
        end
      end
      if (cfg_fmt == FMT_GRAY) m.median = {24'd0, m.median[7:0]};
      m.last = (r + 2 == h && c + 2 == w);
      if (m.last) frames_done++;
      pending_medians = {pending_medians, m};
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // Check every accepted median beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected median beat %h last %b", out_median_pixel,
                                   out_frame_last);
      end else begin
        median_beat_t m;
        m = pending_medians.pop_front();
        beats_checked++;
        if (m.median !== out_median_pixel || m.last !== out_frame_last) begin
          errors++;
          if (errors <= 10)
            $display("median mismatch: expected %h last %b, got %h last %b",
                     m.median, m.last, out_median_pixel, out_frame_last);
        end
      end
    end
  end

  // Receiver stall pattern: calm stretches, light random stalls and long holds.
  int stall_mode = 0, stall_span = 0;
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(2);
      stall_span = $urandom_range(100, 20);
    end
    stall_span--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(9) < 3);
      default: out_stall <= ($urandom_range(19) != 0) ? out_stall : ~out_stall;
    endcase
  end

  // Send one pixel beat; called and returning at a falling edge.
  task automatic send_pixel(input logic [31:0] p);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(5)) @(negedge clk);
      burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(30, 1);
    end
    in_valid = 1'b1;
    in_pixel_in = p;
    do @(posedge clk); while (in_stall);
    predict_median(p);
    beats_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Let the pipeline empty: input idle until every prediction has been seen.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_medians.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input wmf_reg_t idx, input logic [12:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(posedge clk);
    shadow_cfg(idx, v);
    cfg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_frame(input int k, input logic fmt, input int w, input int h);
    drain();
    write_reg(REG_WINDOW_SIZE, 13'(k));
    write_reg(REG_PIXEL_FORMAT, 13'(fmt));
    write_reg(REG_PADDED_WIDTH, 13'(w));
    write_reg(REG_PADDED_HEIGHT, 13'(h));
  endtask

  function automatic logic [31:0] rand_pixel(input int flavor);
    case (flavor)
      0: return $urandom();
      1: return {8'($urandom_range(255)), 24'h0} | 32'($urandom_range(3));
      2: return ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
      default: return ($urandom() & 32'h00FF_FFFF) | ($urandom() & 32'hFF00_0000);
    endcase
  endfunction

  // Reset values: 40 pixels of a full-width first row give nothing, then a
  // small frame keeps the 3-wide gray window from reset.
  task automatic test_reset_defaults();
    for (int i = 0; i < 40; i++) send_pixel($urandom());
    drain();
    write_reg(REG_PADDED_WIDTH, 13'd8);
    write_reg(REG_PADDED_HEIGHT, 13'd6);
    for (int i = 0; i < 48; i++) send_pixel($urandom());
  endtask

  // Field extremes and ties under both formats and the largest window.
  task automatic test_extremes();
    set_frame(7, FMT_ARGB, 9, 9);
    for (int i = 0; i < 81; i++) send_pixel(rand_pixel(2));
    set_frame(3, FMT_GRAY, 4, 4);
    for (int i = 0; i < 16; i++) send_pixel(i[0] ? 32'hFFFF_FF00 : 32'h0000_00FF);
    set_frame(5, FMT_ARGB, 8, 8);
    for (int i = 0; i < 64; i++) send_pixel(rand_pixel(1));
  endtask

  // Out-of-range register values clamp; a window that never fits gives nothing.
  task automatic test_clamps();
    int sides[6] = '{0, 1, 2, 4, 6, 7};
    foreach (sides[s]) begin
      set_frame(sides[s], 1'(s % 2), $urandom_range(3), 13'h1FFF);
      for (int i = 0; i < 40; i++) send_pixel($urandom());
    end
    set_frame(7, FMT_GRAY, 6, 6);
    for (int i = 0; i < 36; i++) send_pixel($urandom());
    set_frame(3, FMT_ARGB, 12'hFFF, 2);
    for (int i = 0; i < 20; i++) send_pixel($urandom());
  endtask

  // Random frames, mostly complete, some cut short by a new setting.
  task automatic test_random_frames();
    int k, w, h, n, fl;
    int target = beats_sent + 250;
    while (beats_sent < target) begin
      k = 3 + 2 * $urandom_range(2);
      w = $urandom_range(16, 4);
      h = $urandom_range(14, 4);
      fl = $urandom_range(3);
      set_frame(k, 1'($urandom_range(1)), w, h);
      n = ($urandom_range(4) == 0) ? $urandom_range(w * h) : w * h * $urandom_range(2, 1);
      for (int i = 0; i < n; i++) send_pixel(rand_pixel(fl));
      if ($urandom_range(3) == 0) drain();
    end
  endtask

  initial begin
    cfg_side = 3;
    cfg_fmt = FMT_GRAY;
    cfg_width = 2048;
    cfg_height = 4096;
    col_pos = 0;
    row_pos = 0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_extremes();
    test_clamps();
    test_random_frames();
    drain();
    $display("Sent %0d pixel beats over %0d register writes; checked %0d medians, %0d frame ends.",
             beats_sent, cfg_writes, beats_checked, frames_done);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching beats", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
design/wmf_pkg.sv
design/wmf_ram.sv
design/wmf_column.sv
design/wmf_rank.sv
design/windowed_median_filter.sv
test/tb_top.sv
